@@ design/bc_pkg.sv @@
// Shared constants and types of the Bezier curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
package bc_pkg;

  localparam int unsigned PT_W   = 32;
  localparam int unsigned MU_W   = 17;
  localparam int unsigned DEG_W  = 4;
  localparam int unsigned IDX_W  = 4;
  localparam logic [MU_W-1:0] MU_ONE = 17'd65536;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef struct packed {
    logic shift;
    logic step;
  } bc_cell_ctl_t;

endpackage
`default_nettype wire

@@ design/bezier_curve_evaluator_top.sv @@
// Top level of the Bezier curve evaluator: point store, cell row and control.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o   | req_type, point_index, point_x/y/z, mu
//  out     | output    | out_valid_o / out_ready_i | curve_x/y/z, overflow
//  cfg     | input     | cfg_valid_i / cfg_ready_o | degree (cfg_data_i)
//
// A load item is written into the point store while the block stays ready. An evaluate item
// makes three passes of the cell row, one per coordinate: each pass fills the row from the
// point store and then performs the n interpolations for degree n and the capture. The
// finished result then moves into the output register once that register is free. Reset
// clears the state, output valid and the degree (to 3) only; the point store holds no reset value.
// A stalled result waits in the output register while the next item is accepted; only a
// second finished result waits for it.
`timescale 1ns / 1ps
`default_nettype none
module bezier_curve_evaluator_top #(
  parameter int unsigned MAX_POINTS  = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       req_type_i,
  input  wire logic [bc_pkg::IDX_W-1:0]   point_index_i,
  input  wire logic signed [bc_pkg::PT_W-1:0] point_x_i,
  input  wire logic signed [bc_pkg::PT_W-1:0] point_y_i,
  input  wire logic signed [bc_pkg::PT_W-1:0] point_z_i,
  input  wire logic [bc_pkg::MU_W-1:0]    mu_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [bc_pkg::PT_W-1:0]  curve_x_o,
  output logic signed [bc_pkg::PT_W-1:0]  curve_y_o,
  output logic signed [bc_pkg::PT_W-1:0]  curve_z_o,
  output logic                            overflow_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [bc_pkg::DEG_W-1:0]   cfg_data_i
);
  import bc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_POINTS);
  localparam longint CHI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam longint CLO = -CHI - 64'sd1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;

  logic [2:0]       state_q, state_d;
  logic [DEG_W-1:0] degree_q;
  logic [NW-1:0]    n_q, n_d, deg_sat;
  logic [NW:0]      ld_q, ld_d;
  logic [NW-1:0]    rd_q, rd_d;
  logic [1:0]       coord_q, coord_d;
  logic [MU_W-1:0]  t_q, t_d;
  logic             ovf_q, ovf_d;
  logic [PT_W-1:0]  res_q [3];
  logic [PT_W-1:0]  res_d [3];
  logic             out_valid_q, out_valid_d;
  logic [PT_W-1:0]  out_x_q, out_y_q, out_z_q;
  logic             out_ovf_q;
  logic             out_load;

  logic             in_acc, ram_we;
  logic [NW-1:0]    ram_raddr;
  logic [3*PT_W-1:0] ram_rdata;
  logic [PT_W-1:0]  feed;
  logic [PT_W-1:0]  cell_val [MAX_POINTS];
  bc_cell_ctl_t     cell_ctl;
  logic [PT_W-1:0]  clamp_val;
  logic             clamp_ovf;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign ram_we      = in_acc && (req_type_i == REQ_LOAD) &&
                       (32'(point_index_i) < 32'(MAX_POINTS));

  always_comb begin
    if (32'(degree_q) > 32'(MAX_POINTS - 1)) begin
      deg_sat = NW'(MAX_POINTS - 1);
    end else begin
      deg_sat = NW'(degree_q);
    end
  end

  bc_ram #(
    .WIDTH(3 * PT_W),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(NW'(point_index_i)),
    .wdata_i({point_z_i, point_y_i, point_x_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_raddr = n_q - ld_q[NW-1:0];

  always_comb begin
    case (coord_q)
      2'd0:    feed = ram_rdata[PT_W-1:0];
      2'd1:    feed = ram_rdata[2*PT_W-1:PT_W];
      default: feed = ram_rdata[3*PT_W-1:2*PT_W];
    endcase
  end

  assign cell_ctl.shift = (state_q == ST_LOAD) && (ld_q != '0);
  assign cell_ctl.step  = (state_q == ST_CALC) && (rd_q != '0);

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    logic [PT_W-1:0] left_v, right_v;
    if (k == 0) begin : g_first
      assign left_v = feed;
    end else begin : g_mid
      assign left_v = cell_val[k-1];
    end
    if (k == MAX_POINTS - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = cell_val[k+1];
    end
    bc_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .t_i    (t_q),
      .left_i (left_v),
      .right_i(right_v),
      .val_o  (cell_val[k])
    );
  end

  always_comb begin
    longint v;
    v         = longint'($signed(cell_val[0]));
    clamp_ovf = 1'b0;
    if (v > CHI) begin
      v         = CHI;
      clamp_ovf = 1'b1;
    end
    if (v < CLO) begin
      v         = CLO;
      clamp_ovf = 1'b1;
    end
    clamp_val = v[PT_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    ld_d        = ld_q;
    rd_d        = rd_q;
    coord_d     = coord_q;
    t_d         = t_q;
    ovf_d       = ovf_q;
    res_d       = res_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (req_type_i == REQ_EVAL)) begin
          t_d     = (mu_i > MU_ONE) ? MU_ONE : mu_i;
          n_d     = deg_sat;
          coord_d = 2'd0;
          ld_d    = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ld_d = ld_q + 1'b1;
        if (ld_q == ({1'b0, n_q} + 1'b1)) begin
          rd_d    = n_q;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (rd_q == '0) begin
          res_d[coord_q] = clamp_val;
          ovf_d          = ovf_q | clamp_ovf;
          if (coord_q == 2'd2) begin
            state_d = ST_FIN;
          end else begin
            coord_d = coord_q + 2'd1;
            ld_d    = '0;
            state_d = ST_LOAD;
          end
        end else begin
          rd_d = rd_q - 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      degree_q    <= DEG_W'(3);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        degree_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    ld_q    <= ld_d;
    rd_q    <= rd_d;
    coord_q <= coord_d;
    t_q     <= t_d;
    ovf_q   <= ovf_d;
    res_q   <= res_d;
    if (out_load) begin
      out_x_q   <= res_q[0];
      out_y_q   <= res_q[1];
      out_z_q   <= res_q[2];
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign curve_x_o   = out_x_q;
  assign curve_y_o   = out_y_q;
  assign curve_z_o   = out_z_q;
  assign overflow_o  = out_ovf_q;

endmodule
`default_nettype wire

@@ design/bc_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module bc_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/bc_cell.sv @@
// One de Casteljau cell: holds a working value, shifts or interpolates.
`timescale 1ns / 1ps
`default_nettype none
module bc_cell (
  input  wire logic                      clk_i,
  input  wire bc_pkg::bc_cell_ctl_t      ctl_i,
  input  wire logic [bc_pkg::MU_W-1:0]   t_i,
  input  wire logic [bc_pkg::PT_W-1:0]   left_i,
  input  wire logic [bc_pkg::PT_W-1:0]   right_i,
  output logic      [bc_pkg::PT_W-1:0]   val_o
);
  import bc_pkg::*;

  logic [PT_W-1:0]     val_q, val_d;
  logic signed [PT_W:0]     diff;
  logic signed [MU_W:0]     t_s;
  logic signed [PT_W+MU_W+1:0] prod;
  logic signed [PT_W+MU_W+1:0] rnd;
  logic signed [PT_W:0]     sum;

  // The step is a + floor(((b - a) * t + 0.5) / 1.0) in Q1.16.
  always_comb begin
    diff  = $signed({right_i[PT_W-1], right_i}) - $signed({val_q[PT_W-1], val_q});
    t_s   = $signed({1'b0, t_i});
    prod  = diff * t_s;
    rnd   = (prod + (PT_W+MU_W+2)'(32768)) >>> 16;
    sum   = $signed({val_q[PT_W-1], val_q}) + rnd[PT_W:0];
    val_d = val_q;
    if (ctl_i.shift) begin
      val_d = left_i;
    end else if (ctl_i.step) begin
      val_d = sum[PT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

@@ design/bc_checker.sv @@
// Port-level checks of the Bezier curve evaluator and their binding.
`timescale 1ns / 1ps
`default_nettype none
module bc_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      req_type_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [bc_pkg::PT_W-1:0]   curve_x_o,
  input wire logic                      overflow_o
);
  import bc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(curve_x_o) && $stable(overflow_o))
    else $error("Result item changed while stalled.");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_EVAL) |=> !in_ready_o)
    else $error("Evaluate item did not occupy the block.");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("Load item produced a result.");

  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("Result appeared without an evaluation.");

endmodule

bind bezier_curve_evaluator_top bc_checker u_bc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .req_type_i (req_type_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .curve_x_o  (curve_x_o),
  .overflow_o (overflow_o)
);
`default_nettype wire
